FILE: rtl/core/icc_pkg.sv
`timescale 1ns / 1ps

package icc_pkg;

   // Store geometry
   localparam int DEPTH      = 65536;
   localparam int COUNT_BITS = 16;
   localparam int STORE_SIZE = (DEPTH < 65536) ? DEPTH : 65536;
   localparam int ADDR_BITS  = $clog2(STORE_SIZE);

   // Field widths
   localparam int POS_BITS    = 16;
   localparam int EXT_BITS    = 17;
   localparam int STATUS_BITS = 2;
   localparam int COV_BITS    = 16;

   localparam logic [EXT_BITS-1:0]  STORE_SIZE_EXT = EXT_BITS'(STORE_SIZE);
   localparam logic [ADDR_BITS-1:0] ADDR_LAST      = ADDR_BITS'(STORE_SIZE - 1);

   // Request kinds
   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_ORDER = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_RANGE = 2'd2;

   // Register indexes
   localparam logic CSR_POSITION_LIMIT = 1'b0;
   localparam logic CSR_GAP_FILL       = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic walk_start;
      logic walk_step;
      logic drain;
      logic read_issue;
      logic rsp_load;
   } icc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic walk_last;
      logic is_read;
      logic add_ok;
   } icc_stat_type;

endpackage

FILE: rtl/core/icc_ctrl.sv
`timescale 1ns / 1ps

module icc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  icc_pkg::icc_stat_type stat,
   output icc_pkg::icc_cmd_type  cmd
);
   import icc_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_WALK   = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence the clear pass, the walk and the result hand-off
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.is_read) begin
               cmd.read_issue = 1'b1;
               state_in       = ST_FINISH;
            end else if (stat.add_ok) begin
               cmd.walk_start = 1'b1;
               state_in       = ST_WALK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            cmd.drain = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result until it is taken
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The walk is entered only from the check step
   a_walk_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |->
         ($past(state_ff) == ST_CHECK || $past(state_ff) == ST_WALK))
      else $error("walk entered without check");

   // A result is never loaded over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.rsp_load)
      else $error("result overwritten");

endmodule

FILE: rtl/core/icc_datapath.sv
`timescale 1ns / 1ps

module icc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  icc_pkg::icc_cmd_type               cmd,
   output icc_pkg::icc_stat_type              stat,
   input  logic                              csr_write,
   input  logic                              csr_index,
   input  logic [icc_pkg::POS_BITS-1:0]      csr_wdata,
   input  logic                              req_type,
   input  logic [icc_pkg::POS_BITS-1:0]      req_range_begin,
   input  logic [icc_pkg::POS_BITS-1:0]      req_range_end,
   input  logic [icc_pkg::POS_BITS-1:0]      req_read_position,
   output logic [icc_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [icc_pkg::COV_BITS-1:0]      rsp_coverage,
   output logic [icc_pkg::EXT_BITS-1:0]      rsp_extent,
   output logic                              rsp_position_valid
);
   import icc_pkg::*;

   logic [COUNT_BITS-1:0]  mem [STORE_SIZE];

   logic [POS_BITS-1:0]    limit_ff;
   logic                   gap_ff;
   logic                   type_ff;
   logic [POS_BITS-1:0]    begin_ff;
   logic [POS_BITS-1:0]    end_ff;
   logic [POS_BITS-1:0]    pos_ff;
   logic [POS_BITS-1:0]    largest_ff;
   logic [EXT_BITS-1:0]    auto_ext_ff;
   logic [ADDR_BITS-1:0]   addr_ff;
   logic [ADDR_BITS-1:0]   addr_in;
   logic [ADDR_BITS-1:0]   wr_addr_ff;
   logic                   pend_ff;
   logic [COUNT_BITS-1:0]  rd_data_ff;

   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [COV_BITS-1:0]    rsp_cov_ff;
   logic [EXT_BITS-1:0]    rsp_ext_ff;
   logic                   rsp_pv_ff;

   logic [EXT_BITS-1:0]    lim_plus;
   logic [EXT_BITS-1:0]    extent;
   logic [EXT_BITS-1:0]    end_plus;
   logic [STATUS_BITS-1:0] add_status;
   logic                   pos_valid;
   logic [COV_BITS-1:0]    read_cov;
   logic                   mem_we;
   logic [ADDR_BITS-1:0]   mem_waddr;
   logic [COUNT_BITS-1:0]  mem_wdata;
   logic                   mem_re;
   logic [ADDR_BITS-1:0]   mem_raddr;

   // Extent in use: grows with the largest end, or follows the limit
   assign lim_plus = {1'b0, limit_ff} + EXT_BITS'(1);
   always_comb begin
      if (limit_ff == '0) begin
         extent = auto_ext_ff;
      end else if (lim_plus > STORE_SIZE_EXT) begin
         extent = STORE_SIZE_EXT;
      end else begin
         extent = lim_plus;
      end
   end

   assign end_plus = {1'b0, end_ff} + EXT_BITS'(1);

   // Classify an add
   always_comb begin
      if (end_ff <= begin_ff) begin
         add_status = STATUS_BAD_ORDER;
      end else if ((limit_ff != '0 && end_ff > limit_ff) ||
                   ({1'b0, end_ff} >= STORE_SIZE_EXT)) begin
         add_status = STATUS_BAD_RANGE;
      end else begin
         add_status = STATUS_OK;
      end
   end

   // Read result, gap positions read as one
   assign pos_valid = ({1'b0, pos_ff} < extent) && ({1'b0, pos_ff} < STORE_SIZE_EXT);
   always_comb begin
      if (!pos_valid) begin
         read_cov = '0;
      end else if (gap_ff && pos_ff >= largest_ff) begin
         read_cov = COV_BITS'(1);
      end else begin
         read_cov = COV_BITS'(rd_data_ff);
      end
   end

   assign stat.clear_last = (addr_ff == ADDR_LAST);
   assign stat.walk_last  = (addr_ff == end_ff[ADDR_BITS-1:0]);
   assign stat.is_read    = (type_ff == REQ_READ);
   assign stat.add_ok     = (add_status == STATUS_OK);

   // Memory ports: clear writes zero, the walk writes back one position behind
   assign mem_we    = cmd.clear_step || (cmd.walk_step && pend_ff) || cmd.drain;
   assign mem_waddr = cmd.clear_step ? addr_ff : wr_addr_ff;
   assign mem_wdata = cmd.clear_step ? '0 : (rd_data_ff + COUNT_BITS'(1));
   assign mem_re    = cmd.walk_step || cmd.read_issue;
   assign mem_raddr = cmd.read_issue ? pos_ff[ADDR_BITS-1:0] : addr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // Advance the walk or clear address
   always_comb begin
      addr_in = addr_ff;
      if (cmd.walk_start) begin
         addr_in = begin_ff[ADDR_BITS-1:0];
      end else if (cmd.clear_step || cmd.walk_step) begin
         addr_in = addr_ff + ADDR_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         pend_ff     <= 1'b0;
         limit_ff    <= '0;
         gap_ff      <= 1'b0;
         largest_ff  <= '0;
         auto_ext_ff <= '0;
      end else begin
         addr_ff <= addr_in;
         pend_ff <= cmd.walk_step;
         if (csr_write) begin
            case (csr_index)
               CSR_POSITION_LIMIT: limit_ff <= csr_wdata;
               CSR_GAP_FILL:       gap_ff   <= csr_wdata[0];
               default:            limit_ff <= limit_ff;
            endcase
         end
         // Commit the accepted add
         if (cmd.drain) begin
            if (end_ff > largest_ff) largest_ff <= end_ff;
            if (end_plus > auto_ext_ff) auto_ext_ff <= end_plus;
         end
      end
   end

   // Capture the item, the write-back address and the result
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         type_ff  <= req_type;
         begin_ff <= req_range_begin;
         end_ff   <= req_range_end;
         pos_ff   <= req_read_position;
      end
      if (cmd.walk_step) begin
         wr_addr_ff <= addr_ff;
      end
      if (cmd.rsp_load) begin
         if (type_ff == REQ_READ) begin
            rsp_status_ff <= STATUS_OK;
            rsp_cov_ff    <= read_cov;
            rsp_pv_ff     <= pos_valid;
         end else begin
            rsp_status_ff <= add_status;
            rsp_cov_ff    <= '0;
            rsp_pv_ff     <= 1'b0;
         end
         rsp_ext_ff <= extent;
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_coverage       = rsp_cov_ff;
   assign rsp_extent         = rsp_ext_ff;
   assign rsp_position_valid = rsp_pv_ff;

   // Write-back never lands on the position being read
   a_port_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("read and write at the same position");

   // The walk stays inside the interval
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (addr_ff <= end_ff[ADDR_BITS-1:0]))
      else $error("walk ran past the interval end");

   // Auto extent tracks the largest end
   a_auto_ext: assert property (@(posedge clock) disable iff (reset)
      (auto_ext_ff == '0) || (auto_ext_ff == {1'b0, largest_ff} + EXT_BITS'(1)))
      else $error("auto extent out of step with largest end");

endmodule

FILE: rtl/core/interval_coverage_counter_core.sv
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// req      req_valid / req_ready   req_type, req_range_begin, req_range_end, req_read_position
// rsp      rsp_valid / rsp_ready   rsp_status, rsp_coverage, rsp_extent, rsp_position_valid
// csr      csr_valid / csr_ready   csr_index, csr_wdata (always ready)
//
// Add of [b, e]: the walk takes one position per cycle through the
// read-modify-write of the single count memory.
// After reset a clearing pass zeroes the memory, one entry a cycle; no item
// is accepted meanwhile, register writes are.
// A stalled result holds in the output register; the next item is accepted
// and worked on, and its result waits until the register is taken.

module interval_coverage_counter_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [icc_pkg::POS_BITS-1:0]      req_range_begin,
   input  logic [icc_pkg::POS_BITS-1:0]      req_range_end,
   input  logic [icc_pkg::POS_BITS-1:0]      req_read_position,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [icc_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [icc_pkg::COV_BITS-1:0]      rsp_coverage,
   output logic [icc_pkg::EXT_BITS-1:0]      rsp_extent,
   output logic                              rsp_position_valid,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [icc_pkg::POS_BITS-1:0]      csr_wdata
);
   import icc_pkg::*;

   icc_cmd_type  cmd;
   icc_stat_type stat;

   assign csr_ready = 1'b1;

   icc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   icc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_type           (req_type),
      .req_range_begin    (req_range_begin),
      .req_range_end      (req_range_end),
      .req_read_position  (req_read_position),
      .rsp_status         (rsp_status),
      .rsp_coverage       (rsp_coverage),
      .rsp_extent         (rsp_extent),
      .rsp_position_valid (rsp_position_valid)
   );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import icc_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [COV_BITS-1:0]    coverage;
      logic [EXT_BITS-1:0]    extent;
      logic                   position_valid;
   } cov_reply_type;

   typedef struct {
      logic                set_cfg;
      logic [POS_BITS-1:0] limit;
      logic                gap;
      logic                kind;
      logic [POS_BITS-1:0] range_begin;
      logic [POS_BITS-1:0] range_end;
      logic [POS_BITS-1:0] read_position;
      logic                typed;
      cov_reply_type       want;
   } stim_row_type;

   typedef struct {
      logic [POS_BITS-1:0] limit;
      logic                gap;
      int                  add_hi;
      int                  read_hi;
      int                  items;
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_type = REQ_READ;
   logic [POS_BITS-1:0]    req_range_begin = '0;
   logic [POS_BITS-1:0]    req_range_end = '0;
   logic [POS_BITS-1:0]    req_read_position = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [COV_BITS-1:0]    rsp_coverage;
   logic [EXT_BITS-1:0]    rsp_extent;
   logic                   rsp_position_valid;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_index = CSR_POSITION_LIMIT;
   logic [POS_BITS-1:0]    csr_wdata = '0;

   // Predictor state: per-position counts, registers, extent tracking
   logic [COUNT_BITS-1:0] count_mem [0:STORE_SIZE-1];
   logic [POS_BITS-1:0]   top_end = '0;
   logic [EXT_BITS-1:0]   grown_extent = '0;
   logic [POS_BITS-1:0]   limit_reg = '0;
   logic                  gap_reg = 1'b0;

   cov_reply_type predicted_replies [$];
   int            mismatches = 0;
   int            cycle_count = 0;
   int            send_quiet = 0;

   always #1 clock = ~clock;

   interval_coverage_counter_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_range_begin    (req_range_begin),
      .req_range_end      (req_range_end),
      .req_read_position  (req_read_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_coverage       (rsp_coverage),
      .rsp_extent         (rsp_extent),
      .rsp_position_valid (rsp_position_valid),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Extent in use under the current limit
   function automatic logic [EXT_BITS-1:0] span_in_use();
      int lim;
      if (limit_reg == '0) return grown_extent;
      lim = int'(limit_reg) + 1;
      if (lim > DEPTH) lim = DEPTH;
      return EXT_BITS'(lim);
   endfunction

   // Apply one item to the predictor state and return its reply
   function automatic cov_reply_type predict_coverage(logic kind, logic [POS_BITS-1:0] rb,
                                                      logic [POS_BITS-1:0] re,
                                                      logic [POS_BITS-1:0] rp);
      cov_reply_type r;
      int i;
      r = '{STATUS_OK, '0, '0, 1'b0};
      if (kind == REQ_ADD) begin
         if (re <= rb) begin
            r.status = STATUS_BAD_ORDER;
         end else if ((limit_reg != '0 && re > limit_reg) || int'(re) >= STORE_SIZE) begin
            r.status = STATUS_BAD_RANGE;
         end else begin
            for (i = int'(rb); i <= int'(re); i++) count_mem[i] = count_mem[i] + 1'b1;
            if (re > top_end) top_end = re;
            if ({1'b0, re} + 17'd1 > grown_extent) grown_extent = {1'b0, re} + 17'd1;
         end
         r.extent = span_in_use();
      end else begin
         r.extent = span_in_use();
         if (int'(rp) < int'(r.extent) && int'(rp) < STORE_SIZE) begin
            r.position_valid = 1'b1;
            if (gap_reg && rp >= top_end) r.coverage = COV_BITS'(1);
            else r.coverage = count_mem[rp];
         end
      end
      return r;
   endfunction

   function automatic stim_row_type mk_row(logic cfg, logic [POS_BITS-1:0] lim, logic gap,
                                           logic kind, logic [POS_BITS-1:0] rb,
                                           logic [POS_BITS-1:0] re, logic [POS_BITS-1:0] rp,
                                           logic typed, logic [STATUS_BITS-1:0] st,
                                           logic [COV_BITS-1:0] cov,
                                           logic [EXT_BITS-1:0] ext,
                                           logic vld);
      stim_row_type r;
      r.set_cfg = cfg;
      r.limit = lim;
      r.gap = gap;
      r.kind = kind;
      r.range_begin = rb;
      r.range_end = re;
      r.read_position = rp;
      r.typed = typed;
      r.want = '{st, cov, ext, vld};
      return r;
   endfunction

   function automatic void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // Draw an idle count, with occasional stretches of no idling
   task automatic pick_stall(inout int quiet, output int stall);
      if (quiet > 0) begin
         quiet--;
         stall = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         quiet = $urandom_range(10, 40);
         stall = 0;
      end else begin
         stall = $urandom_range(0, 14);
      end
   endtask

   // Write both registers; no item is in flight here
   task automatic write_config(input logic [POS_BITS-1:0] lim, input logic gap);
      csr_valid <= 1'b1;
      csr_index <= CSR_POSITION_LIMIT;
      csr_wdata <= lim;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      limit_reg = lim;
      csr_index <= CSR_GAP_FILL;
      csr_wdata <= {{(POS_BITS-1){1'b0}}, gap};
      do @(posedge clock); while (!(csr_valid && csr_ready));
      gap_reg = gap;
      csr_valid <= 1'b0;
   endtask

   // Send one item, draining and reconfiguring first when the row asks
   task automatic issue(input stim_row_type r);
      int idle;
      cov_reply_type predicted;
      pick_stall(send_quiet, idle);
      if (idle > 0 || r.set_cfg) req_valid <= 1'b0;
      if (r.set_cfg) begin
         while (predicted_replies.size() != 0) @(posedge clock);
         write_config(r.limit, r.gap);
      end
      repeat (idle) @(posedge clock);
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_range_begin <= r.range_begin;
      req_range_end <= r.range_end;
      req_read_position <= r.read_position;
      do @(posedge clock); while (!(req_valid && req_ready));
      predicted = predict_coverage(r.kind, r.range_begin, r.range_end, r.read_position);
      if (r.typed) predicted_replies.push_back(r.want);
      else predicted_replies.push_back(predicted);
   endtask

   // Clear the predictor store
   initial begin
      foreach (count_mem[k]) count_mem[k] = '0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Take replies with random stalls and compare with the oldest prediction
   initial begin : reply_side
      int quiet;
      int stall;
      cov_reply_type want;
      quiet = 0;
      forever begin
         pick_stall(quiet, stall);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         if (predicted_replies.size() == 0) begin
            $display("%0t: unexpected item: status %0d coverage %0d extent %0d valid %0d",
                     $time, rsp_status, rsp_coverage, rsp_extent, rsp_position_valid);
            mismatches++;
         end else begin
            want = predicted_replies.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("coverage", want.coverage, rsp_coverage);
            check_field("extent", want.extent, rsp_extent);
            check_field("position_valid", want.position_valid, rsp_position_valid);
         end
      end
   end

   // Stimulus: directed rows, then random phases
   initial begin : request_side
      stim_row_type directed [$];
      stim_row_type row;
      phase_type phases [6];
      int p;
      int n;
      int pick;
      int max_len;
      int len;

      // cfg, limit, gap, kind, begin, end, position, typed, status, coverage, extent, valid
      // empty store, automatic extent still zero
      directed.push_back(mk_row(1, 0, 0, REQ_READ, 0, 0, 0, 1, STATUS_OK, 0, 0, 0));
      directed.push_back(mk_row(0, 0, 0, REQ_READ, 9, 3, 16'hFFFF,
                                1, STATUS_OK, 0, 0, 0));
      directed.push_back(mk_row(0, 0, 0, REQ_ADD, 7, 7, 0, 1, STATUS_BAD_ORDER, 0, 0, 0));
      directed.push_back(mk_row(0, 0, 0, REQ_ADD, 16'hFFFF, 0, 16'hFFFF,
                                1, STATUS_BAD_ORDER, 0, 0, 0));
      // gap fill before any add: whole extent reads as one
      directed.push_back(mk_row(1, 20, 1, REQ_READ, 0, 0, 0, 1, STATUS_OK, 1, 21, 1));
      directed.push_back(mk_row(0, 0, 0, REQ_READ, 0, 0, 20, 1, STATUS_OK, 1, 21, 1));
      directed.push_back(mk_row(0, 0, 0, REQ_READ, 0, 0, 21, 1, STATUS_OK, 0, 21, 0));
      directed.push_back(mk_row(0, 0, 0, REQ_ADD, 3, 21, 0, 1, STATUS_BAD_RANGE, 0, 21, 0));
      directed.push_back(mk_row(0, 0, 0, REQ_ADD, 2, 10, 0, 1, STATUS_OK, 0, 21, 0));
      // gap starts at the largest end itself
      directed.push_back(mk_row(0, 0, 0, REQ_READ, 0, 0, 10, 1, STATUS_OK, 1, 21, 1));
      directed.push_back(mk_row(0, 0, 0, REQ_READ, 0, 0, 9, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(0, 0, 0, REQ_ADD, 5, 8, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(0, 0, 0, REQ_READ, 0, 0, 6, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(0, 0, 0, REQ_READ, 0, 0, 1, 0, 0, 0, 0, 0));
      // largest limit: extent covers the whole store
      directed.push_back(mk_row(1, 16'hFFFF, 0, REQ_READ, 0, 0, 16'hFFFF,
                                1, STATUS_OK, 0, 17'h10000, 1));
      directed.push_back(mk_row(0, 0, 0, REQ_READ, 0, 0, 15, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(0, 0, 0, REQ_ADD, 16'hFFFF, 16'hFFFF, 0,
                                1, STATUS_BAD_ORDER, 0, 17'h10000, 0));
      directed.push_back(mk_row(0, 0, 0, REQ_ADD, 0, 1, 0, 0, 0, 0, 0, 0));
      // back to automatic extent with gap fill
      directed.push_back(mk_row(1, 0, 1, REQ_READ, 0, 0, 11, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(0, 0, 0, REQ_READ, 0, 0, 10, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(0, 0, 0, REQ_ADD, 40, 44, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(0, 0, 0, REQ_READ, 0, 0, 44, 0, 0, 0, 0, 0));

      phases[0] = '{16'd300, 1'b1, 150, 340, 300};
      phases[1] = '{16'd0, 1'b1, 2000, 2100, 300};
      phases[2] = '{16'd1, 1'b0, 1, 3, 100};
      phases[3] = '{16'd0, 1'b0, 0, 65535, 350};
      phases[4] = '{16'hFFFF, 1'b0, 65535, 65535, 350};
      phases[5] = '{16'd0, 1'b1, 65535, 65535, 300};
      phases[3].limit = POS_BITS'($urandom_range(2, 65534));
      phases[3].gap = 1'($urandom_range(0, 1));
      phases[3].add_hi = int'(phases[3].limit);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[k]) issue(directed[k]);

      for (p = 0; p < 6; p++) begin
         for (n = 0; n < phases[p].items; n++) begin
            row = mk_row(n == 0, phases[p].limit, phases[p].gap, REQ_READ,
                         16'($urandom), 16'($urandom), 16'($urandom), 0, 0, 0, 0, 0);
            pick = $urandom_range(0, 99);
            if (p == 4 && n < 2) begin
               // full store span and the top pair
               row.kind = REQ_ADD;
               row.range_begin = (n == 0) ? 16'd0 : 16'hFFFE;
               row.range_end = 16'hFFFF;
            end else if (pick < 45) begin
               // well-formed interval, mostly short
               max_len = (phases[p].add_hi < 32) ? phases[p].add_hi : 32;
               if ($urandom_range(0, 19) == 0 && phases[p].add_hi >= 300) max_len = 300;
               len = $urandom_range(1, max_len);
               row.kind = REQ_ADD;
               row.range_begin = POS_BITS'($urandom_range(0, phases[p].add_hi - len));
               row.range_end = row.range_begin + POS_BITS'(len);
            end else if (pick < 55) begin
               // rejected interval: past the limit or out of order
               row.kind = REQ_ADD;
               if (phases[p].limit != '0 && phases[p].limit != 16'hFFFF &&
                   $urandom_range(0, 1) == 0)
                  row.range_end = POS_BITS'($urandom_range(phases[p].limit + 1, 65535));
               else
                  row.range_end = POS_BITS'($urandom_range(0, row.range_begin));
            end else if ($urandom_range(0, 7) != 0) begin
               row.read_position = POS_BITS'($urandom_range(0, phases[p].read_hi));
            end
            issue(row);
         end
      end

      req_valid <= 1'b0;
      while (predicted_replies.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
